// File: rtl/two_class_oldest_first_queue_core_macros.svh
// assertion macros shared by the queue core modules
`ifndef TWO_CLASS_OLDEST_FIRST_QUEUE_CORE_MACROS_SVH
`define TWO_CLASS_OLDEST_FIRST_QUEUE_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define TCQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TCQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tcq_pkg.sv
// shared types and constants of the two-class oldest-first queue
`timescale 1ns / 1ps
package tcq_pkg;

  localparam int TCQ_DEPTH_DEF = 16;
  localparam int FUNC_W        = 3;
  localparam int TAG_W         = 16;
  localparam int STAMP_W       = 16;
  localparam int STATUS_W      = 2;

  // request codes
  localparam logic [FUNC_W-1:0] FUNC_ENQ_DOG = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ENQ_CAT = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DEQ_ANY = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DEQ_DOG = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DEQ_CAT = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // item classes
  localparam logic KIND_DOG = 1'b0;
  localparam logic KIND_CAT = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic commit;
  } tcq_cmd_t;

endpackage

// File: rtl/tcq_if.sv
// request and result channel interfaces
`timescale 1ns / 1ps
interface tcq_in_if
  import tcq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [TAG_W-1:0]  item_tag;

  modport source (output valid, output func, output item_tag, input ready);
  modport sink   (input valid, input func, input item_tag, output ready);
endinterface

interface tcq_out_if
  import tcq_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                kind;
  logic [TAG_W-1:0]    out_tag;
  logic [STAMP_W-1:0]  out_stamp;

  modport source (output valid, output status, output kind, output out_tag,
                  output out_stamp, input ready);
  modport sink   (input valid, input status, input kind, input out_tag,
                  input out_stamp, output ready);
endinterface

// File: rtl/tcq_datapath.sv
// class stores, head pointers, counts, stamp counter and result register
`timescale 1ns / 1ps
`include "two_class_oldest_first_queue_core_macros.svh"
module tcq_datapath
  import tcq_pkg::*;
#(
  parameter int DEPTH = TCQ_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tcq_cmd_t            cmd,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [TAG_W-1:0]    tag_i,
  output logic [STATUS_W-1:0] status_o,
  output logic                kind_o,
  output logic [TAG_W-1:0]    tag_o,
  output logic [STAMP_W-1:0]  stamp_o
);

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SUM_W   = PTR_W + 1;
  localparam int ENTRY_W = STAMP_W + TAG_W;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [SUM_W-1:0] SUM_WRAP = SUM_W'(DEPTH);

  // captured request
  logic [FUNC_W-1:0] func_r;
  logic [TAG_W-1:0]  tag_r;

  // class stores and their registered head reads
  logic [ENTRY_W-1:0] dog_mem [DEPTH];
  logic [ENTRY_W-1:0] cat_mem [DEPTH];
  logic [ENTRY_W-1:0] dog_rd_r, cat_rd_r;

  // queue bookkeeping
  logic [PTR_W-1:0]   dog_head_r, dog_head_nxt, cat_head_r, cat_head_nxt;
  logic [CNT_W-1:0]   dog_count_r, dog_count_nxt, cat_count_r, cat_count_nxt;
  logic [STAMP_W-1:0] ctr_r, ctr_nxt;

  // result register
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                kind_r, kind_nxt;
  logic [TAG_W-1:0]    tag_out_r, tag_out_nxt;
  logic [STAMP_W-1:0]  stamp_r, stamp_nxt;

  logic               dog_empty, cat_empty, dog_full, cat_full;
  logic               push_dog, push_cat, pop_dog, pop_cat;
  logic [STAMP_W-1:0] stamp_new, stamp_diff;
  logic [SUM_W-1:0]   dog_sum, cat_sum;
  logic [PTR_W-1:0]   dog_tail, cat_tail;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= func_i;
      tag_r  <= tag_i;
    end
  end

  assign dog_empty  = (dog_count_r == '0);
  assign cat_empty  = (cat_count_r == '0);
  assign dog_full   = (dog_count_r == CNT_FULL);
  assign cat_full   = (cat_count_r == CNT_FULL);
  assign stamp_new  = ctr_r + STAMP_W'(1);
  assign stamp_diff = dog_rd_r[ENTRY_W-1:TAG_W] - cat_rd_r[ENTRY_W-1:TAG_W];

  // tail slot = head + count, folded once
  assign dog_sum  = SUM_W'(dog_head_r) + SUM_W'(dog_count_r);
  assign cat_sum  = SUM_W'(cat_head_r) + SUM_W'(cat_count_r);
  assign dog_tail = (dog_sum >= SUM_WRAP) ? PTR_W'(dog_sum - SUM_WRAP) : PTR_W'(dog_sum);
  assign cat_tail = (cat_sum >= SUM_WRAP) ? PTR_W'(cat_sum - SUM_WRAP) : PTR_W'(cat_sum);

  // request decode and result forming
  always_comb begin
    push_dog    = 1'b0;
    push_cat    = 1'b0;
    pop_dog     = 1'b0;
    pop_cat     = 1'b0;
    status_nxt  = STATUS_OK;
    kind_nxt    = KIND_DOG;
    unique case (func_r)
      FUNC_ENQ_DOG: begin
        kind_nxt = KIND_DOG;
        if (dog_full) status_nxt = STATUS_FULL;
        else          push_dog   = 1'b1;
      end
      FUNC_ENQ_CAT: begin
        kind_nxt = KIND_CAT;
        if (cat_full) status_nxt = STATUS_FULL;
        else          push_cat   = 1'b1;
      end
      FUNC_DEQ_ANY: begin
        if (dog_empty && cat_empty) begin
          status_nxt = STATUS_EMPTY;
        end else if (dog_empty || (!cat_empty && !stamp_diff[STAMP_W-1])) begin
          pop_cat  = 1'b1;
          kind_nxt = KIND_CAT;
        end else begin
          pop_dog  = 1'b1;
        end
      end
      FUNC_DEQ_DOG: begin
        kind_nxt = KIND_DOG;
        if (dog_empty) status_nxt = STATUS_EMPTY;
        else           pop_dog    = 1'b1;
      end
      FUNC_DEQ_CAT: begin
        kind_nxt = KIND_CAT;
        if (cat_empty) status_nxt = STATUS_EMPTY;
        else           pop_cat    = 1'b1;
      end
      default: begin
        status_nxt = STATUS_OK;
      end
    endcase

    tag_out_nxt = '0;
    stamp_nxt   = '0;
    if (pop_dog) begin
      tag_out_nxt = dog_rd_r[TAG_W-1:0];
      stamp_nxt   = dog_rd_r[ENTRY_W-1:TAG_W];
    end else if (pop_cat) begin
      tag_out_nxt = cat_rd_r[TAG_W-1:0];
      stamp_nxt   = cat_rd_r[ENTRY_W-1:TAG_W];
    end else if (push_dog || push_cat) begin
      stamp_nxt   = stamp_new;
    end
  end

  // bookkeeping next values
  always_comb begin
    dog_head_nxt  = dog_head_r;
    cat_head_nxt  = cat_head_r;
    dog_count_nxt = dog_count_r;
    cat_count_nxt = cat_count_r;
    ctr_nxt       = ctr_r;
    if (cmd.commit) begin
      if (push_dog || push_cat) ctr_nxt = stamp_new;
      if (push_dog) dog_count_nxt = dog_count_r + CNT_W'(1);
      if (push_cat) cat_count_nxt = cat_count_r + CNT_W'(1);
      if (pop_dog) begin
        dog_count_nxt = dog_count_r - CNT_W'(1);
        dog_head_nxt  = (dog_head_r == PTR_LAST) ? '0 : dog_head_r + PTR_W'(1);
      end
      if (pop_cat) begin
        cat_count_nxt = cat_count_r - CNT_W'(1);
        cat_head_nxt  = (cat_head_r == PTR_LAST) ? '0 : cat_head_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dog_head_r  <= '0;
      cat_head_r  <= '0;
      dog_count_r <= '0;
      cat_count_r <= '0;
      ctr_r       <= '0;
    end else begin
      dog_head_r  <= dog_head_nxt;
      cat_head_r  <= cat_head_nxt;
      dog_count_r <= dog_count_nxt;
      cat_count_r <= cat_count_nxt;
      ctr_r       <= ctr_nxt;
    end
  end

  // dog store: tail write, head read
  always_ff @(posedge clk) begin
    if (cmd.commit && push_dog) begin
      dog_mem[dog_tail] <= {stamp_new, tag_r};
    end
    dog_rd_r <= dog_mem[dog_head_r];
  end

  // cat store: tail write, head read
  always_ff @(posedge clk) begin
    if (cmd.commit && push_cat) begin
      cat_mem[cat_tail] <= {stamp_new, tag_r};
    end
    cat_rd_r <= cat_mem[cat_head_r];
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r  <= status_nxt;
      kind_r    <= kind_nxt;
      tag_out_r <= tag_out_nxt;
      stamp_r   <= stamp_nxt;
    end
  end

  assign status_o = status_r;
  assign kind_o   = kind_r;
  assign tag_o    = tag_out_r;
  assign stamp_o  = stamp_r;

  `TCQ_ASSERT_NOW(a_dog_count_bound, 1'b1, dog_count_r <= CNT_FULL, "dog count above depth")
  `TCQ_ASSERT_NOW(a_cat_count_bound, 1'b1, cat_count_r <= CNT_FULL, "cat count above depth")
  `TCQ_ASSERT_NEXT(a_ctr_hold, !cmd.commit, ctr_r == $past(ctr_r),
                   "stamp counter moved without a commit")

endmodule

// File: rtl/tcq_ctrl.sv
// request sequencer and result valid control
`timescale 1ns / 1ps
`include "two_class_oldest_first_queue_core_macros.svh"
module tcq_ctrl
  import tcq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output tcq_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } tcq_state_t;

  tcq_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept, commit;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  // finish once the result slot is free or being emptied
  assign commit   = (state_r == ST_EXEC) && (!out_valid_r || out_ready);

  // state sequencing
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (commit) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit)         out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign cmd.capture = accept;
  assign cmd.commit  = commit;

  `TCQ_ASSERT_NEXT(a_accept_to_exec, accept, state_r == ST_EXEC,
                   "accepted request did not enter execution")
  `TCQ_ASSERT_NEXT(a_commit_shows, commit, out_valid_r,
                   "committed result not presented")
  `TCQ_ASSERT_NOW(a_no_overwrite, out_valid_r && !out_ready, !commit,
                  "result overwritten before taken")
  `TCQ_ASSERT_NOW(a_no_accept_busy, state_r == ST_EXEC, !accept,
                  "request accepted while busy")

endmodule

// File: rtl/two_class_oldest_first_queue_core.sv
// top level of the two-class oldest-first queue
//
//   channel   dir  handshake          payload
//   in_chan   in   valid/ready        func[2:0], item_tag[15:0]
//   out_chan  out  valid/ready        status[1:0], kind, out_tag[15:0], out_stamp[15:0]
//
// each request is accepted and then executed; execution uses the
// registered head reads of both class stores and writes back store and pointers.
// execute waits while a previous result is held and not taken; a new request
// is accepted while a result waits. rst_n is synchronous, active low; the
// stores need no clearing pass; pointers, counts, stamp counter and sequencer reset.
`timescale 1ns / 1ps
module two_class_oldest_first_queue_core
  import tcq_pkg::*;
#(
  parameter int DEPTH = TCQ_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  tcq_in_if.sink   in_chan,
  tcq_out_if.source out_chan
);

  tcq_cmd_t cmd;

  // sequencer
  tcq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  // queue storage and result forming
  tcq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .func_i   (in_chan.func),
    .tag_i    (in_chan.item_tag),
    .status_o (out_chan.status),
    .kind_o   (out_chan.kind),
    .tag_o    (out_chan.out_tag),
    .stamp_o  (out_chan.out_stamp)
  );

endmodule

// File: tb/two_class_oldest_first_queue_core_test.sv
// self-checking testbench for the two-class oldest-first queue core
`timescale 1ns / 1ps
module two_class_oldest_first_queue_core_test;
  import tcq_pkg::*;

  localparam int QDEPTH       = TCQ_DEPTH_DEF;
  localparam int CLK_HALF     = 5;
  localparam int DRAIN_SLACK  = 16;
  localparam int TIMEOUT_NS   = 40_000_000;
  localparam int REPORT_LIMIT = 10;
  localparam int HOLD_OFF     = 400;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [TAG_W-1:0]   tag;
  } held_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                kind;
    logic [TAG_W-1:0]    tag;
    logic [STAMP_W-1:0]  stamp;
  } reply_t;

  logic clk;
  logic rst_n;

  tcq_in_if  in_chan ();
  tcq_out_if out_chan ();

  two_class_oldest_first_queue_core #(
    .DEPTH(QDEPTH)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // expected contents of both class queues and the stamp counter
  held_item_t         pen [2][QDEPTH];
  int                 pen_head [2]  = '{0, 0};
  int                 pen_count [2] = '{0, 0};
  logic [STAMP_W-1:0] last_stamp    = '0;

  reply_t owed_replies [$];
  int     mismatch_count  = 0;
  int     send_idle_pct   = 0;
  int     recv_stall_pct  = 0;
  int     hold_off_cycles = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // random item tag
  function automatic logic [TAG_W-1:0] rand_tag();
    return TAG_W'($urandom_range(16'hFFFF));
  endfunction

  // push one item into a class, stamping it with the next counter value
  function automatic reply_t admit_item(input logic kind, input logic [TAG_W-1:0] tag);
    reply_t r;
    int     slot;
    r = '{status: STATUS_FULL, kind: kind, tag: '0, stamp: '0};
    if (pen_count[kind] < QDEPTH) begin
      last_stamp = last_stamp + 1'b1;
      slot = (pen_head[kind] + pen_count[kind]) % QDEPTH;
      pen[kind][slot] = '{stamp: last_stamp, tag: tag};
      pen_count[kind]++;
      r.status = STATUS_OK;
      r.stamp  = last_stamp;
    end
    return r;
  endfunction

  // pop the head of one class
  function automatic reply_t release_head(input logic kind);
    reply_t     r;
    held_item_t entry;
    r = '{status: STATUS_EMPTY, kind: kind, tag: '0, stamp: '0};
    if (pen_count[kind] > 0) begin
      entry = pen[kind][pen_head[kind]];
      pen_head[kind] = (pen_head[kind] + 1) % QDEPTH;
      pen_count[kind]--;
      r.status = STATUS_OK;
      r.tag    = entry.tag;
      r.stamp  = entry.stamp;
    end
    return r;
  endfunction

  // expected result of one accepted request
  function automatic reply_t predict_reply(input logic [FUNC_W-1:0] func,
                                           input logic [TAG_W-1:0] tag);
    reply_t             r;
    logic [STAMP_W-1:0] age_gap;
    r = '0;
    case (func)
      FUNC_ENQ_DOG: r = admit_item(KIND_DOG, tag);
      FUNC_ENQ_CAT: r = admit_item(KIND_CAT, tag);
      FUNC_DEQ_DOG: r = release_head(KIND_DOG);
      FUNC_DEQ_CAT: r = release_head(KIND_CAT);
      FUNC_DEQ_ANY: begin
        if (pen_count[KIND_DOG] == 0 && pen_count[KIND_CAT] == 0) begin
          r = '{status: STATUS_EMPTY, kind: KIND_DOG, tag: '0, stamp: '0};
        end else if (pen_count[KIND_DOG] == 0) begin
          r = release_head(KIND_CAT);
        end else if (pen_count[KIND_CAT] == 0) begin
          r = release_head(KIND_DOG);
        end else begin
          // dog is older when the wrapped gap has its top bit set; ties go to cat
          age_gap = pen[KIND_DOG][pen_head[KIND_DOG]].stamp
                  - pen[KIND_CAT][pen_head[KIND_CAT]].stamp;
          r = release_head(age_gap[STAMP_W-1] ? KIND_DOG : KIND_CAT);
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // offer one request, idling first at random, and record what it should return
  task automatic send_request(input logic [FUNC_W-1:0] func, input logic [TAG_W-1:0] tag);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.func     <= func;
    in_chan.item_tag <= tag;
    do @(posedge clk); while (!in_chan.ready);
    owed_replies.insert(owed_replies.size(), predict_reply(func, tag));
  endtask

  // stop offering and wait for every owed result
  task automatic wait_drained();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
  endtask

  // random request mix, leaning toward filling or emptying the queues
  function automatic logic [FUNC_W-1:0] pick_func(input bit filling);
    int roll;
    int enq_share;
    roll      = $urandom_range(99);
    enq_share = filling ? 70 : 30;
    if (roll < 4) return FUNC_DEQ_CAT + 3'($urandom_range(1, 3));
    if (roll < 4 + enq_share) return $urandom_range(1) ? FUNC_ENQ_CAT : FUNC_ENQ_DOG;
    case ($urandom_range(3))
      0, 1: return FUNC_DEQ_ANY;
      2:    return FUNC_DEQ_DOG;
      default: return FUNC_DEQ_CAT;
    endcase
  endfunction

  // empty queues, unused codes, and each choice of dequeue-any
  task automatic test_basic_ops();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(FUNC_DEQ_ANY, 16'hFFFF);
    send_request(FUNC_DEQ_DOG, 16'h1234);
    send_request(FUNC_DEQ_CAT, 16'h0000);
    for (int code = FUNC_DEQ_CAT + 1; code < 2 ** FUNC_W; code++) begin
      send_request(FUNC_W'(code), 16'hFFFF);
    end
    send_request(FUNC_ENQ_DOG, 16'h0000);
    send_request(FUNC_ENQ_CAT, 16'hFFFF);
    send_request(FUNC_DEQ_ANY, 16'h5555);
    send_request(FUNC_ENQ_DOG, 16'hA5A5);
    send_request(FUNC_DEQ_ANY, 16'hAAAA);
    send_request(FUNC_DEQ_ANY, 16'h0F0F);
    send_request(FUNC_ENQ_CAT, 16'h5A5A);
    send_request(FUNC_DEQ_ANY, 16'hF0F0);
    send_request(FUNC_ENQ_DOG, 16'h8001);
    send_request(FUNC_ENQ_CAT, 16'h7FFE);
    send_request(FUNC_DEQ_CAT, 16'h0000);
    send_request(FUNC_DEQ_DOG, 16'hFFFF);
  endtask

  // fill both classes past full, then empty them through dequeue-any
  task automatic test_full_classes();
    send_idle_pct  = 16;
    recv_stall_pct = 16;
    for (int i = 0; i <= QDEPTH; i++) send_request(FUNC_ENQ_DOG, rand_tag());
    for (int i = 0; i <= QDEPTH; i++) send_request(FUNC_ENQ_CAT, rand_tag());
    for (int i = 0; i <= 2 * QDEPTH; i++) send_request(FUNC_DEQ_ANY, rand_tag());
  endtask

  // empty both classes, then interleaved arrivals of both classes drained through dequeue-any
  task automatic test_age_order();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (pen_count[KIND_DOG] > 0) send_request(FUNC_DEQ_DOG, rand_tag());
    while (pen_count[KIND_CAT] > 0) send_request(FUNC_DEQ_CAT, rand_tag());
    for (int i = 0; i < QDEPTH; i++) begin
      send_request($urandom_range(1) ? FUNC_ENQ_CAT : FUNC_ENQ_DOG, rand_tag());
    end
    for (int i = 0; i < QDEPTH; i++) send_request(FUNC_DEQ_ANY, rand_tag());
  endtask

  // long result hold-off while requests keep coming, then a full drain and more requests
  task automatic test_backpressure();
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_cycles = HOLD_OFF;
    for (int i = 0; i < 3 * QDEPTH; i++) begin
      send_request(pick_func(1'b1), rand_tag());
    end
    wait_drained();
    for (int i = 0; i < QDEPTH; i++) send_request(pick_func(1'b0), rand_tag());
  endtask

  // random traffic under one setting of send idling and result stalls
  task automatic test_random_traffic(input int items, input int idle_pct, input int stall_pct);
    bit filling;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    filling        = 1'b1;
    for (int i = 0; i < items; i++) begin
      if (i % 40 == 0) filling = 1'($urandom_range(1));
      send_request(pick_func(filling), rand_tag());
    end
  endtask

  // result side ready, with random stalls and an optional long hold-off
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_chan.ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // compare each accepted result with the oldest owed one
  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = '{status: out_chan.status, kind: out_chan.kind,
              tag: out_chan.out_tag, stamp: out_chan.out_stamp};
      if (owed_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("unexpected result: status %0d kind %0d tag %h stamp %h",
                   got.status, got.kind, got.tag, got.stamp);
        end
      end else begin
        want = owed_replies[0];
        owed_replies.delete(0);
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch: expected status %0d kind %0d tag %h stamp %h, got %0d %0d %h %h",
                     want.status, want.kind, want.tag, want.stamp,
                     got.status, got.kind, got.tag, got.stamp);
          end
        end
      end
    end
  end

  // hard limit on run time
  initial begin
    #(TIMEOUT_NS);
    $display("two_class_oldest_first_queue_core_test: errors");
    $finish;
  end

  // reset and test sequence
  initial begin
    rst_n            = 1'b0;
    in_chan.valid    = 1'b0;
    in_chan.func     = FUNC_ENQ_DOG;
    in_chan.item_tag = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_basic_ops();
    test_full_classes();
    test_age_order();
    test_backpressure();
    test_random_traffic(280, 0, 0);
    test_random_traffic(280, 77, 0);
    test_random_traffic(280, 0, 77);
    test_random_traffic(280, 16, 16);

    wait_drained();
    repeat (DRAIN_SLACK) @(posedge clk);
    if (mismatch_count == 0 && owed_replies.size() == 0) begin
      $display("two_class_oldest_first_queue_core_test: clean");
    end else begin
      $display("two_class_oldest_first_queue_core_test: errors");
    end
    $finish;
  end

endmodule
